// ===== hdl/lpp_pkg.sv =====
// shared types and constants of the pixel plot shadow buffer
package lpp_pkg;

   localparam int NUM_COLUMNS = 102;
   localparam int NUM_PAGES   = 8;

   localparam int FRAME_DEPTH = NUM_COLUMNS * NUM_PAGES;
   localparam int ADDR_W      = $clog2(FRAME_DEPTH);
   localparam int COL_W       = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
   localparam int PAGE_W      = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;

   localparam logic [7:0] MAX_X       = 8'd101;
   localparam logic [7:0] MAX_Y       = 8'd63;
   localparam logic [7:0] NIBBLE_MASK = 8'h0F;
   localparam logic [7:0] COL_LIMIT   = 8'(NUM_COLUMNS - 1);
   localparam logic [7:0] PAGE_LIMIT  = 8'(NUM_PAGES - 1);

   localparam logic [ADDR_W-1:0] CLEAR_LAST = ADDR_W'(FRAME_DEPTH - 1);

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_CMD_BASE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_LOW_CMD_BASE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_HIGH_CMD_BASE = 2'd2;

   localparam logic [7:0] PAGE_CMD_BASE_RST     = 8'd176;
   localparam logic [7:0] COL_LOW_CMD_BASE_RST  = 8'd0;
   localparam logic [7:0] COL_HIGH_CMD_BASE_RST = 8'd16;

   localparam int BEATS = 4;
   localparam int BEAT_W = $clog2(BEATS);
   localparam logic [BEAT_W-1:0] FIRST_BEAT = BEAT_W'(0);
   localparam logic [BEAT_W-1:0] LAST_BEAT  = BEAT_W'(BEATS - 1);

   typedef struct packed {
      logic [7:0] pixel_x;
      logic [7:0] pixel_y;
      logic       set_mode;
   } lpp_req_type;

   typedef struct packed {
      logic [7:0] lcd_byte;
      logic       is_command;
      logic       last_byte;
   } lpp_rsp_type;

   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [7:0]        wr_data;
   } lpp_mem_req_type;

   typedef struct packed {
      logic [7:0] page_cmd;
      logic [7:0] col_low_cmd;
      logic [7:0] col_high_cmd;
      logic [7:0] data;
   } lpp_beat_set_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_WRITE
   } lpp_state_type;

endpackage

// ===== hdl/lcd_pixel_plot_shadow_buffer_core.sv =====
// top level of the pixel plot shadow buffer
//
// req channel: one beat per pixel plot (x, y, set_mode), valid/ready.
// rsp channel: four beats per plot, in order: page command, column low
// command, column high command, then the updated shadow data byte with
// last_byte set. is_command is high on the three command beats.
// csr port: write enable, register index, data; takes effect at once.
// flow: a plot is accepted in the idle state, its shadow byte is read in the
// read state, and in the write state the updated byte is written back and
// loaded into the serializer, which then raises rsp_valid for the first beat.
// plot rate is bounded by the single rsp port, which moves one byte a cycle
// while rsp_ready is high; the read-modify-write runs idle, read, write.
// the next plot is accepted while the current bytes are still going out.
// a stall on rsp holds the current beat; once the next plot is read it
// waits for the serializer before writing back, and no further plot is taken.
// reset: clears the command base registers to their defaults and then sweeps
// the 816-byte frame store to zero, one byte a cycle, before req_ready first
// rises; csr writes are taken during the sweep.
module lcd_pixel_plot_shadow_buffer_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  lpp_pkg::lpp_req_type          req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output lpp_pkg::lpp_rsp_type          rsp_payload,
   input  logic                          csr_wr_en,
   input  logic [lpp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                    csr_wr_data
);

   lpp_pkg::lpp_mem_req_type  mem_req;
   lpp_pkg::lpp_beat_set_type beat_set;
   logic [7:0]                rd_data;
   logic                      tx_free;
   logic                      tx_load;

   lpp_plot_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .mem_req     (mem_req),
      .rd_data     (rd_data),
      .tx_free     (tx_free),
      .tx_load     (tx_load),
      .beat_set    (beat_set)
   );

   lpp_frame_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   lpp_beat_tx u_tx (
      .clock       (clock),
      .reset       (reset),
      .tx_load     (tx_load),
      .beat_set    (beat_set),
      .tx_free     (tx_free),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== hdl/lpp_frame_mem.sv =====
// shadow frame store: one write port, one registered read port
module lpp_frame_mem (
   input  logic                        clock,
   input  lpp_pkg::lpp_mem_req_type    mem_req,
   output logic [7:0]                  rd_data
);

   logic [7:0] mem [lpp_pkg::FRAME_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/lpp_plot_ctrl.sv =====
// clear sweep, coordinate decode and read-modify-write sequencer
module lpp_plot_ctrl (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  lpp_pkg::lpp_req_type                 req_payload,
   input  logic                                 csr_wr_en,
   input  logic [lpp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [7:0]                           csr_wr_data,
   output lpp_pkg::lpp_mem_req_type             mem_req,
   input  logic [7:0]                           rd_data,
   input  logic                                 tx_free,
   output logic                                 tx_load,
   output lpp_pkg::lpp_beat_set_type            beat_set
);

   lpp_pkg::lpp_state_type state_ff, state_in;

   logic [lpp_pkg::ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic [lpp_pkg::ADDR_W-1:0] addr_ff, addr_in;
   logic [lpp_pkg::COL_W-1:0]  col_ff, col_in;
   logic [lpp_pkg::PAGE_W-1:0] page_ff, page_in;
   logic [7:0]                 mask_ff, mask_in;
   logic                       mode_ff, mode_in;

   logic [7:0] page_cmd_base_ff;
   logic [7:0] col_low_cmd_base_ff;
   logic [7:0] col_high_cmd_base_ff;

   logic       accept;
   logic [7:0] x_sat, y_sat, col_sat, page_sat;
   logic [7:0] new_data;

   assign accept = req_valid && req_ready;

   // coordinate clamp and address
   always_comb begin
      x_sat    = (req_payload.pixel_x > lpp_pkg::MAX_X) ? lpp_pkg::MAX_X : req_payload.pixel_x;
      y_sat    = (req_payload.pixel_y > lpp_pkg::MAX_Y) ? lpp_pkg::MAX_Y : req_payload.pixel_y;
      col_sat  = (x_sat > lpp_pkg::COL_LIMIT) ? lpp_pkg::COL_LIMIT : x_sat;
      page_sat = ((y_sat >> 3) > lpp_pkg::PAGE_LIMIT) ? lpp_pkg::PAGE_LIMIT : (y_sat >> 3);
      col_in   = col_sat[lpp_pkg::COL_W-1:0];
      page_in  = page_sat[lpp_pkg::PAGE_W-1:0];
      mask_in  = 8'(8'd1 << y_sat[2:0]);
      mode_in  = req_payload.set_mode;
      addr_in  = lpp_pkg::ADDR_W'(lpp_pkg::ADDR_W'(col_in) * lpp_pkg::ADDR_W'(lpp_pkg::NUM_PAGES)
                 + lpp_pkg::ADDR_W'(page_in));
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         addr_ff <= addr_in;
         col_ff  <= col_in;
         page_ff <= page_in;
         mask_ff <= mask_in;
         mode_ff <= mode_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         page_cmd_base_ff     <= lpp_pkg::PAGE_CMD_BASE_RST;
         col_low_cmd_base_ff  <= lpp_pkg::COL_LOW_CMD_BASE_RST;
         col_high_cmd_base_ff <= lpp_pkg::COL_HIGH_CMD_BASE_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            lpp_pkg::CSR_PAGE_CMD_BASE:     page_cmd_base_ff     <= csr_wr_data;
            lpp_pkg::CSR_COL_LOW_CMD_BASE:  col_low_cmd_base_ff  <= csr_wr_data;
            lpp_pkg::CSR_COL_HIGH_CMD_BASE: col_high_cmd_base_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      unique case (state_ff)
         lpp_pkg::ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == lpp_pkg::CLEAR_LAST) begin
               state_in = lpp_pkg::ST_IDLE;
            end
         end
         lpp_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = lpp_pkg::ST_READ;
            end
         end
         lpp_pkg::ST_READ: begin
            state_in = lpp_pkg::ST_WRITE;
         end
         lpp_pkg::ST_WRITE: begin
            if (tx_free) begin
               state_in = lpp_pkg::ST_IDLE;
            end
         end
         default: state_in = lpp_pkg::ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= lpp_pkg::ST_CLEAR;
         clr_addr_ff <= '0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   assign new_data = mode_ff ? (rd_data | mask_ff) : (rd_data ^ mask_ff);

   // outputs
   always_comb begin
      req_ready       = 1'b0;
      tx_load         = 1'b0;
      mem_req.rd_en   = 1'b0;
      mem_req.rd_addr = addr_ff;
      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = addr_ff;
      mem_req.wr_data = new_data;
      unique case (state_ff)
         lpp_pkg::ST_CLEAR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = clr_addr_ff;
            mem_req.wr_data = '0;
         end
         lpp_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         lpp_pkg::ST_READ: begin
            mem_req.rd_en = 1'b1;
         end
         lpp_pkg::ST_WRITE: begin
            mem_req.wr_en = tx_free;
            tx_load       = tx_free;
         end
         default: ;
      endcase
   end

   always_comb begin
      beat_set.page_cmd     = page_cmd_base_ff | 8'(page_ff);
      beat_set.col_low_cmd  = col_low_cmd_base_ff | (8'(col_ff) & lpp_pkg::NIBBLE_MASK);
      beat_set.col_high_cmd = col_high_cmd_base_ff | 8'(col_ff >> 4);
      beat_set.data         = new_data;
   end

endmodule

// ===== hdl/lpp_beat_tx.sv =====
// four-beat output register and serializer
module lpp_beat_tx (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       tx_load,
   input  lpp_pkg::lpp_beat_set_type  beat_set,
   output logic                       tx_free,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output lpp_pkg::lpp_rsp_type       rsp_payload
);

   logic [7:0]                 byte_ff [lpp_pkg::BEATS];
   logic [lpp_pkg::BEAT_W-1:0] beat_ff, beat_in;
   logic                       busy_ff, busy_in;
   logic                       last;

   assign last    = (beat_ff == lpp_pkg::LAST_BEAT);
   assign tx_free = !busy_ff || (rsp_ready && last);

   always_comb begin
      beat_in = beat_ff;
      busy_in = busy_ff;
      if (tx_load) begin
         beat_in = lpp_pkg::FIRST_BEAT;
         busy_in = 1'b1;
      end else if (busy_ff && rsp_ready) begin
         beat_in = beat_ff + 1'b1;
         busy_in = !last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff <= lpp_pkg::FIRST_BEAT;
         busy_ff <= 1'b0;
      end else begin
         beat_ff <= beat_in;
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tx_load) begin
         byte_ff[0] <= beat_set.page_cmd;
         byte_ff[1] <= beat_set.col_low_cmd;
         byte_ff[2] <= beat_set.col_high_cmd;
         byte_ff[3] <= beat_set.data;
      end
   end

   assign rsp_valid              = busy_ff;
   assign rsp_payload.lcd_byte   = byte_ff[beat_ff];
   assign rsp_payload.is_command = !last;
   assign rsp_payload.last_byte  = last;

endmodule

// ===== sim/lcd_pixel_plot_shadow_buffer_core_tb.sv =====
// self-checking testbench of the pixel plot shadow buffer core
`timescale 1ns / 1ps

module lcd_pixel_plot_shadow_buffer_core_tb;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 20;
   localparam int X_LIMIT      = 101;
   localparam int Y_LIMIT      = 63;

   localparam logic [7:0] NIBBLE            = 8'h0F;
   localparam logic [7:0] PAGE_BASE_DEFAULT = 8'd176;
   localparam logic [7:0] LOW_BASE_DEFAULT  = 8'd0;
   localparam logic [7:0] HIGH_BASE_DEFAULT = 8'd16;

   localparam logic [lpp_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid;
   logic                          req_ready;
   lpp_pkg::lpp_req_type          req_payload;
   logic                          rsp_valid;
   logic                          rsp_ready;
   lpp_pkg::lpp_rsp_type          rsp_payload;
   logic                          csr_wr_en;
   logic [lpp_pkg::CSR_IDX_W-1:0] csr_index;
   logic [7:0]                    csr_wr_data;

   logic [7:0]           shadow_frame [lpp_pkg::FRAME_DEPTH];
   logic [7:0]           page_base;
   logic [7:0]           col_low_base;
   logic [7:0]           col_high_base;
   lpp_pkg::lpp_req_type pending_plots [$];
   lpp_pkg::lpp_rsp_type expected_beats [$];
   lpp_pkg::lpp_rsp_type want;
   int                   send_idle_pct  = 0;
   int                   recv_stall_pct = 0;
   int                   fail_count     = 0;
   int                   cycle_count    = 0;
   logic [7:0]           recent_x       = 8'd0;
   logic [7:0]           recent_y       = 8'd0;

   lcd_pixel_plot_shadow_buffer_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #6 clock = ~clock;

   function automatic void predict_plot(input lpp_pkg::lpp_req_type plot);
      int                   col;
      int                   row;
      int                   page;
      int                   addr;
      logic [7:0]           bit_mask;
      logic [7:0]           data;
      lpp_pkg::lpp_rsp_type beat;
      col = (plot.pixel_x > X_LIMIT) ? X_LIMIT : int'(plot.pixel_x);
      row = (plot.pixel_y > Y_LIMIT) ? Y_LIMIT : int'(plot.pixel_y);
      if (col > lpp_pkg::NUM_COLUMNS - 1) col = lpp_pkg::NUM_COLUMNS - 1;
      page = row >> 3;
      if (page > lpp_pkg::NUM_PAGES - 1) page = lpp_pkg::NUM_PAGES - 1;
      bit_mask = 8'd1 << (row % 8);
      addr = col * lpp_pkg::NUM_PAGES + page;
      data = plot.set_mode ? (shadow_frame[addr] | bit_mask)
                           : (shadow_frame[addr] ^ bit_mask);
      shadow_frame[addr] = data;
      beat.is_command = 1'b1;
      beat.last_byte  = 1'b0;
      beat.lcd_byte   = page_base | 8'(page);
      expected_beats.push_back(beat);
      beat.lcd_byte   = col_low_base | (8'(col) & NIBBLE);
      expected_beats.push_back(beat);
      beat.lcd_byte   = col_high_base | 8'(col >> 4);
      expected_beats.push_back(beat);
      beat.lcd_byte   = data;
      beat.is_command = 1'b0;
      beat.last_byte  = 1'b1;
      expected_beats.push_back(beat);
   endfunction

   function automatic lpp_pkg::lpp_req_type random_plot();
      lpp_pkg::lpp_req_type plot;
      int                   pick;
      pick = $urandom_range(9);
      plot.set_mode = 1'($urandom_range(1));
      if (pick < 6) begin
         plot.pixel_x = 8'($urandom_range(X_LIMIT));
         plot.pixel_y = 8'($urandom_range(Y_LIMIT));
      end else if (pick < 8) begin
         plot.pixel_x = 8'($urandom_range(255));
         plot.pixel_y = 8'($urandom_range(255));
      end else begin
         // same shadow byte as the previous plot, maybe another bit
         plot.pixel_x = recent_x;
         plot.pixel_y = recent_y ^ 8'($urandom_range(7));
      end
      recent_x = plot.pixel_x;
      recent_y = plot.pixel_y;
      return plot;
   endfunction

   task automatic queue_plot(input logic [7:0] x, input logic [7:0] y, input logic mode);
      lpp_pkg::lpp_req_type plot;
      plot.pixel_x  = x;
      plot.pixel_y  = y;
      plot.set_mode = mode;
      pending_plots.push_back(plot);
   endtask

   task automatic write_reg(input logic [lpp_pkg::CSR_IDX_W-1:0] idx,
                            input logic [7:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      case (idx)
         lpp_pkg::CSR_PAGE_CMD_BASE:     page_base     = value;
         lpp_pkg::CSR_COL_LOW_CMD_BASE:  col_low_base  = value;
         lpp_pkg::CSR_COL_HIGH_CMD_BASE: col_high_base = value;
         default: ;
      endcase
   endtask

   task automatic set_bases(input logic [7:0] pg, input logic [7:0] lo, input logic [7:0] hi);
      write_reg(lpp_pkg::CSR_PAGE_CMD_BASE, pg);
      write_reg(lpp_pkg::CSR_COL_LOW_CMD_BASE, lo);
      write_reg(lpp_pkg::CSR_COL_HIGH_CMD_BASE, hi);
      write_reg(CSR_UNMAPPED, 8'($urandom_range(255)));
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (pending_plots.size() != 0 || req_valid || expected_beats.size() != 0)
         @(negedge clock);
   endtask

   task automatic run_phase(input int send_pct, input int stall_pct, input int count);
      @(negedge clock);
      send_idle_pct  = send_pct;
      recv_stall_pct = stall_pct;
      repeat (count) pending_plots.push_back(random_plot());
      wait_drained();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) predict_plot(req_payload);
         if (pending_plots.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid   <= 1'b1;
            req_payload <= pending_plots.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_beats.size() == 0) begin
               $display("%0t: unexpected beat, expected none, actual %p", $time, rsp_payload);
               fail_count++;
            end else begin
               want = expected_beats.pop_front();
               if (rsp_payload.lcd_byte !== want.lcd_byte) begin
                  $display("%0t: lcd_byte expected %h actual %h",
                           $time, want.lcd_byte, rsp_payload.lcd_byte);
                  fail_count++;
               end
               if (rsp_payload.is_command !== want.is_command) begin
                  $display("%0t: is_command expected %b actual %b",
                           $time, want.is_command, rsp_payload.is_command);
                  fail_count++;
               end
               if (rsp_payload.last_byte !== want.last_byte) begin
                  $display("%0t: last_byte expected %b actual %b",
                           $time, want.last_byte, rsp_payload.last_byte);
                  fail_count++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("lcd_pixel_plot_shadow_buffer_core regression: fail");
         $finish;
      end
   end

   initial begin
      req_valid     = 1'b0;
      req_payload   = '0;
      rsp_ready     = 1'b0;
      csr_wr_en     = 1'b0;
      csr_index     = lpp_pkg::CSR_PAGE_CMD_BASE;
      csr_wr_data   = 8'd0;
      page_base     = PAGE_BASE_DEFAULT;
      col_low_base  = LOW_BASE_DEFAULT;
      col_high_base = HIGH_BASE_DEFAULT;
      foreach (shadow_frame[i]) shadow_frame[i] = 8'd0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      // set, set again, toggle off and on, then clamped corners, nibble and page boundaries and other points
      queue_plot(8'd0, 8'd0, 1'b1);
      queue_plot(8'd0, 8'd0, 1'b1);
      queue_plot(8'd0, 8'd0, 1'b0);
      queue_plot(8'd0, 8'd0, 1'b0);
      queue_plot(8'd101, 8'd63, 1'b1);
      queue_plot(8'd102, 8'd64, 1'b1);
      queue_plot(8'd255, 8'd255, 1'b0);
      queue_plot(8'd15, 8'd7, 1'b1);
      queue_plot(8'd16, 8'd8, 1'b1);
      queue_plot(8'd17, 8'd15, 1'b0);
      queue_plot(8'd100, 8'd62, 1'b1);
      queue_plot(8'd101, 8'd0, 1'b0);
      queue_plot(8'd50, 8'd56, 1'b1);
      queue_plot(8'd50, 8'd57, 1'b1);
      queue_plot(8'd50, 8'd255, 1'b0);
      queue_plot(8'd255, 8'd0, 1'b1);
      queue_plot(8'd0, 8'd255, 1'b1);
      queue_plot(8'hAA, 8'h55, 1'b0);
      queue_plot(8'h55, 8'hAA, 1'b1);
      queue_plot(8'd31, 8'd31, 1'b0);
      queue_plot(8'd64, 8'd39, 1'b1);
      queue_plot(8'd127, 8'd128, 1'b0);
      wait_drained();
      set_bases(8'd0, 8'd0, 8'd0);
      run_phase(77, 0, 22);
      set_bases(8'd255, 8'd255, 8'd255);
      run_phase(0, 77, 22);
      set_bases(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
      run_phase(32, 32, 22);
      set_bases(PAGE_BASE_DEFAULT, LOW_BASE_DEFAULT, HIGH_BASE_DEFAULT);
      run_phase(0, 0, 22);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("lcd_pixel_plot_shadow_buffer_core regression: pass");
      else
         $display("lcd_pixel_plot_shadow_buffer_core regression: fail");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/lpp_pkg.sv
hdl/lpp_frame_mem.sv
hdl/lpp_plot_ctrl.sv
hdl/lpp_beat_tx.sv
hdl/lcd_pixel_plot_shadow_buffer_core.sv
sim/lcd_pixel_plot_shadow_buffer_core_tb.sv
